FILE: rtl/core/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg: shared types and constants of the result frame checker
// Transaction payload structs, function and status codes, frame constants.
// ----------------------------------------------------------------------------
package rfc_pkg;

   localparam int unsigned CsrIndexWidth = 4;
   localparam int unsigned CsrDataWidth  = 32;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CSR_TIMEOUT_TICKS   = 4'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_FREQ_LIMIT_BITS = 4'd1;

   localparam logic [15:0] TIMEOUT_RESET    = 16'd200;
   localparam logic [30:0] FREQ_LIMIT_RESET = 31'h459C_4000;

   // Function codes of a request.
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_BYTE  = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // Result status codes.
   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_TIMEOUT   = 3'd1;
   localparam logic [2:0] STATUS_BAD_START = 3'd2;
   localparam logic [2:0] STATUS_BAD_END   = 3'd3;
   localparam logic [2:0] STATUS_BAD_SUM   = 3'd4;
   localparam logic [2:0] STATUS_BAD_FREQ  = 3'd5;

   localparam logic [7:0]  START_MARK   = 8'hAA;
   localparam logic [7:0]  END_MARK     = 8'hBB;
   localparam logic [30:0] EXP_ALL_ONES = 31'h7F80_0000;

   // Byte positions within the frame.
   localparam logic [3:0] POS_FIRST    = 4'd0;
   localparam logic [3:0] POS_LAST_PAY = 4'd8;
   localparam logic [3:0] POS_CHECKSUM = 4'd9;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] freq_bits;
      logic [31:0] compute_bits;
   } rsp_type;

   // Everything the judge needs to rate one complete frame.
   typedef struct packed {
      logic [7:0]  first_byte;
      logic [7:0]  last_byte;
      logic [7:0]  xor_sum;
      logic [7:0]  checksum_byte;
      logic [31:0] freq_bits;
      logic [30:0] freq_limit;
   } frame_check_type;

endpackage

FILE: rtl/core/rfc_judge.sv
// ----------------------------------------------------------------------------
// rfc_judge: status decision for one complete frame
// Checks start mark, end mark, checksum and frequency range, in that order.
// ----------------------------------------------------------------------------
module rfc_judge (
   input  rfc_pkg::frame_check_type frame,
   output logic [2:0]               status
);
   import rfc_pkg::*;

   logic [30:0] mag;
   logic        freq_bad;

   assign mag = frame.freq_bits[30:0];

   // A NaN frequency passes, minus zero passes, and a NaN limit lets every
   // positive frequency through.
   always_comb begin
      if (mag > EXP_ALL_ONES) begin
         freq_bad = 1'b0;
      end else if (frame.freq_bits[31]) begin
         freq_bad = (mag != 31'd0);
      end else if (frame.freq_limit > EXP_ALL_ONES) begin
         freq_bad = 1'b0;
      end else begin
         freq_bad = (mag > frame.freq_limit);
      end
   end

   always_comb begin
      if (frame.first_byte != START_MARK) begin
         status = STATUS_BAD_START;
      end else if (frame.last_byte != END_MARK) begin
         status = STATUS_BAD_END;
      end else if (frame.xor_sum != frame.checksum_byte) begin
         status = STATUS_BAD_SUM;
      end else if (freq_bad) begin
         status = STATUS_BAD_FREQ;
      end else begin
         status = STATUS_OK;
      end
   end

endmodule

FILE: rtl/core/result_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// result_frame_checker_unit: receiver and checker for an 11-byte reply frame
// Collects start, payload, checksum and end bytes and reports one status.
// ----------------------------------------------------------------------------
// A start transaction arms the receiver, which then takes exactly eleven byte
// transactions with no resynchronization: start mark 0xAA, eight payload bytes
// (little-endian frequency word, then compute time word), an XOR checksum of
// the payload and end mark 0xBB. The eleventh byte produces one result with a
// status and both raw words; tick transactions count toward the timeout and a
// timeout produces a result with zero words. Bytes and ticks while idle, and
// the unused function code, produce nothing. The block takes one transaction
// per clock while the result side keeps up: a request is captured in an input
// register, processed by the frame state logic once the output register can
// take its result, and its result lands in the output register. The only
// stall comes from the result side: while a result waits in the output
// register, one further request can still be captured. Configuration writes
// are always taken and must only be issued while the block is idle.
module result_frame_checker_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  rfc_pkg::req_type                     req_payload,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rfc_pkg::rsp_type                     rsp_payload,
   // Configuration write channel.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rfc_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [rfc_pkg::CsrDataWidth-1:0]     csr_wdata
);
   import rfc_pkg::*;

   // Configuration registers.
   logic [15:0] timeout_ff;
   logic [30:0] freq_limit_ff;

   // Input register.
   logic    in_valid_ff;
   req_type in_item_ff;

   // Frame state.
   logic        waiting_ff,  waiting_in;
   logic [3:0]  pos_ff,      pos_in;
   logic [7:0]  xor_ff,      xor_in;
   logic [7:0]  first_ff,    first_in;
   logic [7:0]  check_ff,    check_in;
   logic [63:0] payload_ff,  payload_in;
   logic [15:0] tick_ff,     tick_in;

   // Output register.
   logic    out_valid_ff;
   rsp_type out_item_ff;

   logic            process_fire;
   logic            emit;
   rsp_type         result;
   logic [15:0]     tick_next;
   frame_check_type frame;
   logic [2:0]      judged_status;

   // The stored request moves on when the output register is free or is
   // being emptied in this cycle.
   assign process_fire = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || process_fire;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_item_ff;

   assign tick_next = tick_ff + 16'd1;

   assign frame.first_byte    = first_ff;
   assign frame.last_byte     = in_item_ff.rx_byte;
   assign frame.xor_sum       = xor_ff;
   assign frame.checksum_byte = check_ff;
   assign frame.freq_bits     = payload_ff[31:0];
   assign frame.freq_limit    = freq_limit_ff;

   rfc_judge judge_inst (
      .frame  (frame),
      .status (judged_status)
   );

   // Frame state update for the request held in the input register.
   always_comb begin
      waiting_in = waiting_ff;
      pos_in     = pos_ff;
      xor_in     = xor_ff;
      first_in   = first_ff;
      check_in   = check_ff;
      payload_in = payload_ff;
      tick_in    = tick_ff;
      emit       = 1'b0;
      result.status       = STATUS_OK;
      result.freq_bits    = payload_ff[31:0];
      result.compute_bits = payload_ff[63:32];

      case (in_item_ff.func)
         FUNC_START: begin
            // Starting again while waiting simply restarts the frame.
            waiting_in = 1'b1;
            pos_in     = POS_FIRST;
            xor_in     = 8'd0;
            first_in   = 8'd0;
            check_in   = 8'd0;
            payload_in = 64'd0;
            tick_in    = 16'd0;
         end
         FUNC_TICK: begin
            if (waiting_ff) begin
               tick_in = tick_next;
               // A wrapped count also times out; a zero limit expires on the first tick.
               if (tick_next >= timeout_ff || tick_next == 16'd0) begin
                  waiting_in          = 1'b0;
                  emit                = 1'b1;
                  result.status       = STATUS_TIMEOUT;
                  result.freq_bits    = 32'd0;
                  result.compute_bits = 32'd0;
               end
            end
         end
         FUNC_BYTE: begin
            if (waiting_ff) begin
               if (pos_ff == POS_FIRST) begin
                  first_in = in_item_ff.rx_byte;
                  pos_in   = pos_ff + 4'd1;
               end else if (pos_ff <= POS_LAST_PAY) begin
                  for (int i = 0; i < 8; i++) begin
                     if (pos_ff == 4'(i + 1)) begin
                        payload_in[i*8 +: 8] = in_item_ff.rx_byte;
                     end
                  end
                  xor_in = xor_ff ^ in_item_ff.rx_byte;
                  pos_in = pos_ff + 4'd1;
               end else if (pos_ff == POS_CHECKSUM) begin
                  check_in = in_item_ff.rx_byte;
                  pos_in   = pos_ff + 4'd1;
               end else begin
                  // End byte: the frame is complete.
                  waiting_in    = 1'b0;
                  pos_in        = POS_FIRST;
                  emit          = 1'b1;
                  result.status = judged_status;
               end
            end
         end
         default: begin
            // Unused function code: no effect.
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         freq_limit_ff <= FREQ_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_TIMEOUT_TICKS) begin
            timeout_ff <= csr_wdata[15:0];
         end else if (csr_index == CSR_FREQ_LIMIT_BITS) begin
            freq_limit_ff <= csr_wdata[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         pos_ff     <= POS_FIRST;
         tick_ff    <= 16'd0;
      end else if (process_fire) begin
         waiting_ff <= waiting_in;
         pos_ff     <= pos_in;
         tick_ff    <= tick_in;
      end
      if (process_fire) begin
         xor_ff     <= xor_in;
         first_ff   <= first_in;
         check_ff   <= check_in;
         payload_ff <= payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (process_fire) begin
         out_valid_ff <= emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (process_fire && emit) begin
         out_item_ff <= result;
      end
   end

endmodule

FILE: dv/result_frame_checker_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// result_frame_checker_unit_test: self-checking bench for the reply frame checker
// Drives start, byte, tick and unused-code transactions under random flow
// control and compares every result with a cycle-free model of the frame receiver.
// ----------------------------------------------------------------------------
module result_frame_checker_unit_test;
   import rfc_pkg::*;

   localparam int CLOCK_PERIOD  = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int HOLD_CYCLES   = 60;

   // The package leaves function code 3 unnamed; the block must ignore it.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // ------------------------------------------------------------------------
   // Frame receiver model and result scoreboard.
   // ------------------------------------------------------------------------
   class frame_scoreboard;
      logic [15:0] timeout_ticks;
      logic [30:0] freq_limit;
      bit          armed;
      logic [3:0]  byte_pos;
      logic [7:0]  xor_acc;
      logic [7:0]  lead_byte;
      logic [7:0]  sum_byte;
      logic [63:0] payload_acc;
      logic [15:0] tick_cnt;
      rsp_type     frame_verdicts[$];
      int          mismatch_count;

      function new();
         timeout_ticks  = TIMEOUT_RESET;
         freq_limit     = FREQ_LIMIT_RESET;
         armed          = 1'b0;
         mismatch_count = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         byte_pos    = '0;
         xor_acc     = '0;
         lead_byte   = '0;
         sum_byte    = '0;
         payload_acc = '0;
         tick_cnt    = '0;
      endfunction

      function void write_register(logic [CsrIndexWidth-1:0] index,
                                   logic [CsrDataWidth-1:0] data);
         if (index == CSR_TIMEOUT_TICKS) begin
            timeout_ticks = data[15:0];
         end else if (index == CSR_FREQ_LIMIT_BITS) begin
            freq_limit = data[30:0];
         end
      endfunction

      // NaN frequencies pass, negative values other than minus zero fail,
      // and a NaN limit lets every positive value through.
      function bit freq_rejected(logic [31:0] f);
         if (f[30:0] > EXP_ALL_ONES) return 1'b0;
         if (f[31]) return f[30:0] != '0;
         if (freq_limit > EXP_ALL_ONES) return 1'b0;
         return f[30:0] > freq_limit;
      endfunction

      function logic [2:0] rate_frame(logic [7:0] last_byte);
         if (lead_byte != START_MARK) return STATUS_BAD_START;
         if (last_byte != END_MARK) return STATUS_BAD_END;
         if (xor_acc != sum_byte) return STATUS_BAD_SUM;
         if (freq_rejected(payload_acc[31:0])) return STATUS_BAD_FREQ;
         return STATUS_OK;
      endfunction

      function void take_request(req_type req);
         rsp_type verdict;
         int      shift;
         if (req.func == FUNC_START) begin
            clear_frame();
            armed = 1'b1;
            return;
         end
         if (!armed) return;
         if (req.func == FUNC_TICK) begin
            tick_cnt = tick_cnt + 16'd1;
            if (tick_cnt >= timeout_ticks || tick_cnt == 16'd0) begin
               armed                = 1'b0;
               verdict.status       = STATUS_TIMEOUT;
               verdict.freq_bits    = '0;
               verdict.compute_bits = '0;
               frame_verdicts.push_back(verdict);
            end
            return;
         end
         if (req.func != FUNC_BYTE) return;
         if (byte_pos == POS_FIRST) begin
            lead_byte = req.rx_byte;
         end else if (byte_pos <= POS_LAST_PAY) begin
            shift       = 8 * (int'(byte_pos) - 1);
            payload_acc = payload_acc | (64'(req.rx_byte) << shift);
            xor_acc     = xor_acc ^ req.rx_byte;
         end else if (byte_pos == POS_CHECKSUM) begin
            sum_byte = req.rx_byte;
         end else begin
            armed                = 1'b0;
            verdict.status       = rate_frame(req.rx_byte);
            verdict.freq_bits    = payload_acc[31:0];
            verdict.compute_bits = payload_acc[63:32];
            frame_verdicts.push_back(verdict);
            byte_pos = '0;
            return;
         end
         byte_pos = byte_pos + 4'd1;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH @%0t: %s", $time, what);
         mismatch_count++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (frame_verdicts.size() == 0) begin
            report_mismatch($sformatf("result with none outstanding, status %0d", got.status));
            return;
         end
         want = frame_verdicts.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d", got.status, want.status));
         if (got.freq_bits !== want.freq_bits)
            report_mismatch($sformatf("freq_bits %h, predicted %h",
                                      got.freq_bits, want.freq_bits));
         if (got.compute_bits !== want.compute_bits)
            report_mismatch($sformatf("compute_bits %h, predicted %h",
                                      got.compute_bits, want.compute_bits));
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and the block under test.
   // ------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_payload;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_payload;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   frame_scoreboard board;
   int              items_sent  = 0;
   int              gap_pct     = 0;
   int              stall_pct   = 0;
   int              hold_cycles = 0;
   int              cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   result_frame_checker_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // All stimulus changes on the falling edge, so every signal is stable at
   // the rising edge where this block samples the three handshakes. The model
   // sees register writes and requests in exactly the order the block takes
   // them; a result can never be due at the edge that accepts its request.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) board.write_register(csr_index, csr_wdata);
         if (req_valid && req_ready) board.take_request(req_payload);
         if (rsp_valid && rsp_ready) board.check_result(rsp_payload);
      end
   end

   // A run that hangs on a handshake is stopped here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL result_frame_checker_unit");
         $finish;
      end
   end

   // Result side. Normally ready is high with random stall bursts. When the
   // stimulus asks for a hold, ready stays low for a long stretch counted here,
   // so results back up into the output register and the block has to push
   // back on the request side.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles != 0) begin
            rsp_ready = 1'b0;
            for (int k = 1; k < hold_cycles; k++) @(negedge clock);
            hold_cycles = 0;
         end else if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Drops valid for a burst set by n, starting at the next falling edge.
   task automatic idle_sender(int n);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // Offers one request and returns at the rising edge that accepts it. The
   // caller must follow with another request or a settle, both of which act
   // at the very next falling edge, so an accepted item is never offered twice.
   task automatic send_request(logic [1:0] func, logic [7:0] value);
      req_type item;
      if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
         idle_sender($urandom_range(1, 7));
      item.func    = func;
      item.rx_byte = value;
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Withdraws the request, waits for every predicted result, then gives the
   // block time to settle, since an ignored byte or tick may still be in its
   // pipeline when the last result has come out.
   task automatic settle_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (board.frame_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] index, logic [CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic int pick_idle_rate();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 15;
         default: return 35;
      endcase
   endfunction

   // Frequency words lean on the range edges: both zeros, both infinities,
   // NaNs of either sign, the limit itself and its neighbors.
   function automatic logic [31:0] pick_frequency();
      logic [31:0] lim;
      lim = {1'b0, board.freq_limit};
      case ($urandom_range(0, 13))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2: return 32'h7F80_0000;
         3: return 32'hFF80_0000;
         4: return {9'h0FF, 23'($urandom_range(1, 32'h7F_FFFF))};
         5: return {9'h1FF, 23'($urandom)};
         6: return lim;
         7: return lim + 32'd1;
         8: return lim - 32'd1;
         9: return 32'($urandom);
         10: return 32'h7F7F_FFFF;
         default: return 32'($urandom_range(0, (lim > 32'h7F80_0000) ? 32'h7F80_0000 : lim));
      endcase
   endfunction

   // One armed frame with random content and, now and then, a corrupted
   // mark, checksum or payload byte. Ticks, unused codes and one restart may
   // fall between the bytes; a restart sends the whole frame again.
   task automatic send_frame();
      logic [7:0]  frame [0:10];
      logic [31:0] freq;
      logic [31:0] comp;
      logic [7:0]  sum;
      int          i;
      int          spot;
      bit          restarted;
      freq = pick_frequency();
      comp = $urandom;
      sum  = '0;
      frame[0] = START_MARK;
      for (i = 0; i < 4; i++) begin
         frame[1 + i] = freq[8 * i +: 8];
         frame[5 + i] = comp[8 * i +: 8];
      end
      for (i = 1; i <= 8; i++) sum = sum ^ frame[i];
      frame[9]  = sum;
      frame[10] = END_MARK;
      case ($urandom_range(0, 9))
         0: frame[0] = 8'($urandom);
         1: frame[10] = 8'($urandom);
         2: frame[9] = sum ^ 8'($urandom_range(1, 255));
         3: begin
            spot        = $urandom_range(1, 8);
            frame[spot] = frame[spot] ^ 8'($urandom_range(1, 255));
         end
         4: begin
            frame[0]  = ~START_MARK;
            frame[9]  = ~sum;
            frame[10] = ~END_MARK;
         end
         default: ;
      endcase
      send_request(FUNC_START, 8'($urandom));
      restarted = 1'b0;
      i = 0;
      while (i < 11) begin
         if ($urandom_range(0, 15) == 0) send_request(FUNC_TICK, 8'($urandom));
         if ($urandom_range(0, 29) == 0) send_request(FUNC_UNUSED, 8'($urandom));
         if (!restarted && $urandom_range(0, 39) == 0) begin
            restarted = 1'b1;
            send_request(FUNC_START, 8'($urandom));
            i = 0;
         end
         send_request(FUNC_BYTE, frame[i]);
         i++;
      end
   endtask

   // A reply that never completes: a few bytes, then enough ticks to expire.
   // With a long timeout only a few ticks are sent and the frame stays open.
   task automatic send_timeout();
      int ticks;
      send_request(FUNC_START, 8'($urandom));
      repeat ($urandom_range(0, 5)) send_request(FUNC_BYTE, 8'($urandom));
      if (board.timeout_ticks == 16'd0) begin
         ticks = 1;
      end else if (board.timeout_ticks <= 16'd24) begin
         ticks = int'(board.timeout_ticks);
      end else begin
         ticks = 3;
      end
      repeat (ticks) send_request(FUNC_TICK, 8'($urandom));
   endtask

   // One configuration followed by a random mix of frames, timeouts and
   // stray transactions. The upper half of the timeout write carries random bits
   // and the top bit of the limit write may be set; the block must drop both.
   task automatic run_phase(logic [15:0] timeout, logic [31:0] limit, int budget, bit idling);
      int target;
      settle_block();
      gap_pct   = idling ? pick_idle_rate() : 0;
      stall_pct = idling ? pick_idle_rate() : 0;
      write_csr(CSR_TIMEOUT_TICKS, {16'($urandom), timeout});
      write_csr(CSR_FREQ_LIMIT_BITS, limit);
      target = items_sent + budget;
      while (items_sent < target) begin
         case ($urandom_range(0, 9))
            0: send_timeout();
            1: repeat ($urandom_range(1, 4))
                  send_request(2'($urandom_range(0, 3)), 8'($urandom));
            default: send_frame();
         endcase
      end
   endtask

   // ------------------------------------------------------------------------
   // Test sequence.
   // ------------------------------------------------------------------------
   initial begin
      // A well-formed frame carrying exactly 5000.0 and an all-ones compute
      // word; the checksum of 00 40 9C 45 FF FF FF FF is 99.
      logic [7:0] exact_frame [0:9];
      exact_frame = '{8'h00, 8'h40, 8'h9C, 8'h45, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                      8'h99, END_MARK};

      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset configuration. Bytes, a tick and the unused
      // code while idle must all be dropped. Then a frame is begun and
      // abandoned by a second start, and the fresh frame hits the frequency
      // limit exactly, with a tick and an unused code mixed into it.
      gap_pct   = 20;
      stall_pct = 20;
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_BYTE, 8'hFF);
      send_request(FUNC_TICK, 8'h00);
      send_request(FUNC_UNUSED, 8'hFF);
      send_request(FUNC_START, 8'h00);
      send_request(FUNC_BYTE, START_MARK);
      send_request(FUNC_BYTE, 8'h00);
      send_request(FUNC_START, 8'hFF);
      send_request(FUNC_BYTE, START_MARK);
      send_request(FUNC_UNUSED, 8'h00);
      send_request(FUNC_TICK, 8'hFF);
      foreach (exact_frame[j]) send_request(FUNC_BYTE, exact_frame[j]);

      // Random phases sweep the registers across their extremes: a zero
      // limit, the largest finite limit, an infinite limit and a NaN limit,
      // and timeouts of zero, one, a few ticks and the full 16-bit range.
      run_phase(16'd1, 32'h0000_0000, 80, 1'b1);
      run_phase(16'd0, 32'h7F7F_FFFF, 80, 1'b1);
      run_phase(16'hFFFF, 32'hFFFF_FFFF, 80, 1'b1);
      run_phase(16'd5, 32'h7F80_0000, 80, 1'b1);
      run_phase(16'($urandom_range(1, 20)), $urandom, 80, 1'b1);
      run_phase(16'($urandom_range(1, 20)), $urandom, 80, 1'b1);

      // Back-pressure: with a one-tick timeout every start and tick pair
      // yields a result. The result side is held off for a long stretch
      // while requests keep coming, so the block must stall its input.
      settle_block();
      gap_pct   = 0;
      stall_pct = 0;
      write_csr(CSR_TIMEOUT_TICKS, 32'd1);
      hold_cycles = HOLD_CYCLES;
      repeat (20) begin
         send_request(FUNC_START, 8'($urandom));
         send_request(FUNC_TICK, 8'($urandom));
      end

      // The closing phase runs at full rate on both sides with the reset
      // configuration restored.
      run_phase(TIMEOUT_RESET, {1'b0, FREQ_LIMIT_RESET}, 60, 1'b0);

      settle_block();
      if (board.mismatch_count == 0) begin
         $display("PASS result_frame_checker_unit");
      end else begin
         $display("FAIL result_frame_checker_unit");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/rfc_pkg.sv
rtl/core/rfc_judge.sv
rtl/core/result_frame_checker_unit.sv
dv/result_frame_checker_unit_test.sv
